// ===== rtl/core/aabb_accumulate_and_transform_defines.svh =====
// Assertion macros for the checker file of this block.
`ifndef AABB_ACCUMULATE_AND_TRANSFORM_DEFINES_SVH
`define AABB_ACCUMULATE_AND_TRANSFORM_DEFINES_SVH

// Same-cycle implication, disabled while the reset is asserted.
`define AAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("aabb transform check failed");

// Next-cycle implication, disabled while rst_n is low.
`define AAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("aabb transform check failed");

`endif

// ===== rtl/core/aat_pkg.sv =====
`timescale 1ns / 1ps

package aat_pkg;

    // Coordinate and coefficient formats (signed, FRAC_BITS fraction bits).
    localparam int COORD_W   = 32;
    localparam int COEF_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = COORD_W + COEF_W;
    // Three products plus the scaled translation need two extra bits.
    localparam int SUM_W     = PROD_W + 2;
    localparam int NUM_AXES  = 3;

    localparam int CFG_W     = 2 * COEF_W;
    localparam int NUM_CFG   = 6;
    localparam int CFG_IDX_W = 3;

    // Queue between front and back; must be a power of two.
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [PROD_W-1:0]  t_prod;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic [CFG_W-1:0]          t_cfg;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;
    typedef logic [1:0]                t_op;

    localparam t_op OP_POINT      = 2'd0;
    localparam t_op OP_POINT_LAST = 2'd1;
    localparam t_op OP_BOX        = 2'd2;

    localparam t_cfg_idx REG_ROW0_COLS01 = 3'd0;
    localparam t_cfg_idx REG_ROW0_COLS23 = 3'd1;
    localparam t_cfg_idx REG_ROW1_COLS01 = 3'd2;
    localparam t_cfg_idx REG_ROW1_COLS23 = 3'd3;
    localparam t_cfg_idx REG_ROW2_COLS01 = 3'd4;
    localparam t_cfg_idx REG_ROW2_COLS23 = 3'd5;

    // Identity matrix, no translation.
    localparam t_cfg CFG_RESET [NUM_CFG] = '{
        64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000,
        64'h0, 64'h0, 64'h0000_0000_0001_0000
    };

    // One classified item as it waits in the queue.
    typedef struct packed {
        t_op                   op;
        t_coord [NUM_AXES-1:0] a;
        t_coord [NUM_AXES-1:0] b;
    } t_item;

endpackage

// ===== rtl/core/aat_in_if.sv =====
`timescale 1ns / 1ps

interface aat_in_if;
    logic                 valid;
    logic                 ready;
    logic                 action;
    aat_pkg::t_coord      first_x;
    aat_pkg::t_coord      first_y;
    aat_pkg::t_coord      first_z;
    aat_pkg::t_coord      second_x;
    aat_pkg::t_coord      second_y;
    aat_pkg::t_coord      second_z;
    logic                 last;

    modport source (
        output valid, action, first_x, first_y, first_z,
               second_x, second_y, second_z, last,
        input  ready
    );
    modport sink (
        input  valid, action, first_x, first_y, first_z,
               second_x, second_y, second_z, last,
        output ready
    );
endinterface

// ===== rtl/core/aat_out_if.sv =====
`timescale 1ns / 1ps

interface aat_out_if;
    logic            valid;
    logic            ready;
    aat_pkg::t_coord min_x;
    aat_pkg::t_coord min_y;
    aat_pkg::t_coord min_z;
    aat_pkg::t_coord max_x;
    aat_pkg::t_coord max_y;
    aat_pkg::t_coord max_z;

    modport source (
        output valid, min_x, min_y, min_z, max_x, max_y, max_z,
        input  ready
    );
    modport sink (
        input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface

// ===== rtl/core/aat_front.sv =====
`timescale 1ns / 1ps

module aat_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aat_in_if.sink          i_in,
    output logic            o_item_valid,
    output aat_pkg::t_item  o_item,
    input  logic            i_item_ready
);

    localparam int PTR_W = $clog2(aat_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(aat_pkg::QUEUE_DEPTH + 1);

    aat_pkg::t_item r_mem [aat_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    aat_pkg::t_item   w_entry;
    logic             push;
    logic             pop;

    // Classify the incoming beat; a box ignores last.
    always_comb begin
        if (i_in.action) begin
            w_entry.op = aat_pkg::OP_BOX;
        end else if (i_in.last) begin
            w_entry.op = aat_pkg::OP_POINT_LAST;
        end else begin
            w_entry.op = aat_pkg::OP_POINT;
        end
        w_entry.a = {i_in.first_z, i_in.first_y, i_in.first_x};
        w_entry.b = {i_in.second_z, i_in.second_y, i_in.second_x};
    end

    assign i_in.ready   = (r_cnt != CNT_W'(aat_pkg::QUEUE_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rptr];
    assign push         = i_in.valid && i_in.ready;
    assign pop          = o_item_valid && i_item_ready;
    assign n_cnt        = r_cnt + CNT_W'(push) - CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= w_entry;
        end
    end

endmodule

// ===== rtl/core/aat_back.sv =====
`timescale 1ns / 1ps

module aat_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  aat_pkg::t_cfg_idx   i_cfg_idx,
    input  aat_pkg::t_cfg       i_cfg_data,
    input  logic                i_item_valid,
    input  aat_pkg::t_item      i_item,
    output logic                o_item_ready,
    aat_out_if.source           o_res
);

    localparam int NA      = aat_pkg::NUM_AXES;
    localparam int CW      = aat_pkg::COEF_W;
    localparam int SAT_TOP = aat_pkg::FRAC_BITS + aat_pkg::COORD_W - 1;

    // Arithmetic shift right by FRAC_BITS and saturation to the coordinate range.
    function automatic aat_pkg::t_coord sat_narrow(input aat_pkg::t_sum s);
        logic fits;
        fits = (&s[aat_pkg::SUM_W-1:SAT_TOP]) || !(|s[aat_pkg::SUM_W-1:SAT_TOP]);
        if (fits) begin
            return s[aat_pkg::FRAC_BITS +: aat_pkg::COORD_W];
        end else if (s[aat_pkg::SUM_W-1]) begin
            return {1'b1, {(aat_pkg::COORD_W-1){1'b0}}};
        end else begin
            return {1'b0, {(aat_pkg::COORD_W-1){1'b1}}};
        end
    endfunction

    aat_pkg::t_cfg   r_cfg [aat_pkg::NUM_CFG];
    aat_pkg::t_coef  coef  [NA][4];

    // Stage 1: products of the linear coefficients with both corner values.
    logic            r_v1;
    aat_pkg::t_op    r_op1;
    aat_pkg::t_coord r_a1  [NA];
    aat_pkg::t_prod  r_pa1 [NA][NA];
    aat_pkg::t_prod  r_pb1 [NA][NA];
    // Stage 2: per-term minimum and maximum.
    logic            r_v2;
    aat_pkg::t_op    r_op2;
    aat_pkg::t_coord r_a2  [NA];
    aat_pkg::t_prod  r_lo2 [NA][NA];
    aat_pkg::t_prod  r_hi2 [NA][NA];
    // Stage 3: output register.
    logic            r_v3;
    aat_pkg::t_coord r_min3 [NA];
    aat_pkg::t_coord r_max3 [NA];
    // Running point box.
    logic            r_open;
    aat_pkg::t_coord r_run_min [NA];
    aat_pkg::t_coord r_run_max [NA];

    aat_pkg::t_coord n_run_min [NA];
    aat_pkg::t_coord n_run_max [NA];
    aat_pkg::t_coord w_box_min [NA];
    aat_pkg::t_coord w_box_max [NA];
    logic            take1;
    logic            take2;
    logic            emits2;
    logic            is_point2;

    for (genvar g = 0; g < NA; g++) begin : g_row
        assign coef[g][0] = r_cfg[2*g][CW-1:0];
        assign coef[g][1] = r_cfg[2*g][2*CW-1:CW];
        assign coef[g][2] = r_cfg[2*g+1][CW-1:0];
        assign coef[g][3] = r_cfg[2*g+1][2*CW-1:CW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < aat_pkg::NUM_CFG; i++) begin
                r_cfg[i] <= aat_pkg::CFG_RESET[i];
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aat_pkg::REG_ROW0_COLS01: r_cfg[0] <= i_cfg_data;
                aat_pkg::REG_ROW0_COLS23: r_cfg[1] <= i_cfg_data;
                aat_pkg::REG_ROW1_COLS01: r_cfg[2] <= i_cfg_data;
                aat_pkg::REG_ROW1_COLS23: r_cfg[3] <= i_cfg_data;
                aat_pkg::REG_ROW2_COLS01: r_cfg[4] <= i_cfg_data;
                aat_pkg::REG_ROW2_COLS23: r_cfg[5] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign take2        = r_v2 && (!r_v3 || o_res.ready);
    assign take1        = r_v1 && (!r_v2 || take2);
    assign o_item_ready = !r_v1 || take1;
    assign emits2       = (r_op2 != aat_pkg::OP_POINT);
    assign is_point2    = (r_op2 == aat_pkg::OP_POINT) || (r_op2 == aat_pkg::OP_POINT_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_item_ready) begin
                r_v1 <= i_item_valid;
            end
            if (!r_v2 || take2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item_valid && o_item_ready) begin
            r_op1 <= i_item.op;
            for (int j = 0; j < NA; j++) begin
                r_a1[j] <= aat_pkg::t_coord'(i_item.a[j]);
                for (int r = 0; r < NA; r++) begin
                    r_pa1[r][j] <= aat_pkg::PROD_W'(coef[r][j])
                                 * aat_pkg::PROD_W'(aat_pkg::t_coord'(i_item.a[j]));
                    r_pb1[r][j] <= aat_pkg::PROD_W'(coef[r][j])
                                 * aat_pkg::PROD_W'(aat_pkg::t_coord'(i_item.b[j]));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take1) begin
            r_op2 <= r_op1;
            for (int j = 0; j < NA; j++) begin
                r_a2[j] <= r_a1[j];
                for (int r = 0; r < NA; r++) begin
                    if (r_pa1[r][j] < r_pb1[r][j]) begin
                        r_lo2[r][j] <= r_pa1[r][j];
                        r_hi2[r][j] <= r_pb1[r][j];
                    end else begin
                        r_lo2[r][j] <= r_pb1[r][j];
                        r_hi2[r][j] <= r_pa1[r][j];
                    end
                end
            end
        end
    end

    // Each output axis is separable, so the extreme corner is the sum of extreme terms.
    always_comb begin
        for (int r = 0; r < NA; r++) begin
            w_box_min[r] = sat_narrow(aat_pkg::SUM_W'(r_lo2[r][0]) + aat_pkg::SUM_W'(r_lo2[r][1])
                + aat_pkg::SUM_W'(r_lo2[r][2])
                + (aat_pkg::SUM_W'(coef[r][3]) <<< aat_pkg::FRAC_BITS));
            w_box_max[r] = sat_narrow(aat_pkg::SUM_W'(r_hi2[r][0]) + aat_pkg::SUM_W'(r_hi2[r][1])
                + aat_pkg::SUM_W'(r_hi2[r][2])
                + (aat_pkg::SUM_W'(coef[r][3]) <<< aat_pkg::FRAC_BITS));
        end
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_run_min[i] = (!r_open || (r_a2[i] < r_run_min[i])) ? r_a2[i] : r_run_min[i];
            n_run_max[i] = (!r_open || (r_a2[i] > r_run_max[i])) ? r_a2[i] : r_run_max[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3   <= 1'b0;
            r_open <= 1'b0;
        end else begin
            if (take2 && emits2) begin
                r_v3 <= 1'b1;
            end else if (o_res.ready) begin
                r_v3 <= 1'b0;
            end
            if (take2 && is_point2) begin
                r_open <= (r_op2 == aat_pkg::OP_POINT);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take2 && is_point2) begin
            r_run_min <= n_run_min;
            r_run_max <= n_run_max;
        end
        if (take2 && emits2) begin
            if (is_point2) begin
                r_min3 <= n_run_min;
                r_max3 <= n_run_max;
            end else begin
                r_min3 <= w_box_min;
                r_max3 <= w_box_max;
            end
        end
    end

    assign o_res.valid = r_v3;
    assign o_res.min_x = r_min3[0];
    assign o_res.min_y = r_min3[1];
    assign o_res.min_z = r_min3[2];
    assign o_res.max_x = r_max3[0];
    assign o_res.max_y = r_max3[1];
    assign o_res.max_z = r_max3[2];

endmodule

// ===== rtl/core/aabb_accumulate_and_transform.sv =====
`timescale 1ns / 1ps

// Bounding box accumulator and affine box transformer.
// The input channel i_in carries one item per beat. A point beat (action 0)
// widens the running box, and a point beat marked last returns that box on
// o_res and closes the run. A box beat (action 1) returns the bounding box of
// its eight corners after the configured 3x4 affine matrix, in signed Q16.16,
// with each coordinate floored and saturated; the point run is left as it is.
// The matrix is written through i_cfg_we, i_cfg_idx and i_cfg_data while the
// block is idle; writes to indexes above five are dropped.
// Throughput is one beat per cycle while o_res is not stalled. A result passes
// through the input queue, the multiplier stage and the min/max stage into
// the output register before it appears on o_res.
// Reset restores the identity matrix, empties the queue and the pipeline and
// closes any open run. When the receiver stalls, the result holds in the
// output register, the pipeline stops behind it, and the four-entry queue
// keeps taking beats until it is full, after which i_in.ready drops.
module aabb_accumulate_and_transform (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  aat_pkg::t_cfg_idx  i_cfg_idx,
    input  aat_pkg::t_cfg      i_cfg_data,
    aat_in_if.sink             i_in,
    aat_out_if.source          o_res
);

    logic           item_valid;
    logic           item_ready;
    aat_pkg::t_item item;

    // The front classifies beats and queues them.
    aat_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_ready (item_ready)
    );

    // The back holds the matrix, runs the transform pipeline and the point run.
    aat_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_ready (item_ready),
        .o_res        (o_res)
    );

endmodule

// ===== rtl/core/aat_checker.sv =====
`timescale 1ns / 1ps
`include "aabb_accumulate_and_transform_defines.svh"

module aat_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    aat_in_if.sink     i_in,
    aat_out_if.source  o_res
);

    // A stalled result stays offered with the same min_x, max_x and min_z.
    `AAT_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid && $stable(o_res.min_x) && $stable(o_res.max_x) && $stable(o_res.min_z))

    // Every result is a proper box, whether from a point run or a transform.
    `AAT_ASSERT_SAME(a_res_ordered, i_clk, i_rst_n, o_res.valid, (o_res.min_x <= o_res.max_x) && (o_res.min_y <= o_res.max_y) && (o_res.min_z <= o_res.max_z))

    // Reset empties the output register.
    `AAT_ASSERT_NEXT(a_rst_out_empty, i_clk, 1'b1, !i_rst_n, !o_res.valid)

    // Reset empties the queue, so the block is ready right after it.
    `AAT_ASSERT_NEXT(a_rst_in_ready, i_clk, 1'b1, !i_rst_n, i_in.ready)

endmodule

bind aabb_accumulate_and_transform aat_checker u_aat_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_res   (o_res)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the bounding box accumulator and affine box
// transformer. Input beats come from a queue that the stimulus process fills
// phase by phase. A clocked driver presents them with random gaps. A clocked
// monitor takes result beats with random stalls and compares each one with
// the oldest predicted box. The matrix is rewritten only between phases, once
// the block has drained.
module tb;
    import aat_pkg::*;

    // Codes of the action bit of an input beat.
    localparam logic ACT_POINT = 1'b0;
    localparam logic ACT_BOX   = 1'b1;

    // Register indexes past the matrix; the block must drop these writes.
    localparam t_cfg_idx REG_BEYOND_FIRST = t_cfg_idx'(NUM_CFG);
    localparam t_cfg_idx REG_BEYOND_LAST  = '1;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 10;
    localparam int MAX_IDLE      = 10;

    // Exact sums need 66 bits; a wider signed accumulator leaves headroom.
    localparam int WIDE_W = 80;
    localparam logic signed [WIDE_W-1:0] WIDE_MAX =
        (80'sd1 <<< (COORD_W - 1)) - 80'sd1;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -(80'sd1 <<< (COORD_W - 1));

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_coef  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
    localparam t_coef  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
    localparam t_coef  COEF_ONE  = t_coef'(1) <<< FRAC_BITS;

    typedef enum int {
        MAT_IDENTITY, MAT_SHIFTED, MAT_ALL_MAX, MAT_ALL_MIN,
        MAT_ZERO, MAT_MODERATE, MAT_WILD
    } matrix_kind_e;

    typedef struct {
        logic   action;
        t_coord first [3];
        t_coord second [3];
        logic   last;
    } beat_t;

    typedef struct {
        t_coord lo [3];
        t_coord hi [3];
    } box_t;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    t_cfg_idx i_cfg_idx;
    t_cfg     i_cfg_data;

    aat_in_if  in_bus ();
    aat_out_if res_bus ();

    aabb_accumulate_and_transform u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_res      (res_bus)
    );

    // Our own copy of the matrix and of the running point box.
    t_cfg   matrix_shadow [NUM_CFG];
    t_coord run_lo [3];
    t_coord run_hi [3];
    bit     run_open;

    beat_t pending_beats [$];
    box_t  expected_boxes [$];

    int  beats_queued;
    int  beats_accepted;
    int  error_count;
    int  cycle_count;
    // While set, neither side idles, so beats flow back to back.
    bit  calm;

    string lo_name [3] = '{"min_x", "min_y", "min_z"};
    string hi_name [3] = '{"max_x", "max_y", "max_z"};

    always #5 i_clk = ~i_clk;

    // One output axis of the affine map: the three products and the scaled
    // translation are summed exactly, floored by the shift, then saturated.
    function automatic t_coord affine_axis(int r, t_coord x, t_coord y, t_coord z);
        t_coef c0, c1, c2, tr;
        logic signed [WIDE_W-1:0] acc, term;
        c0 = matrix_shadow[2*r][COEF_W-1:0];
        c1 = matrix_shadow[2*r][CFG_W-1:COEF_W];
        c2 = matrix_shadow[2*r+1][COEF_W-1:0];
        tr = matrix_shadow[2*r+1][CFG_W-1:COEF_W];
        acc = c0 * x;
        term = c1 * y;
        acc = acc + term;
        term = c2 * z;
        acc = acc + term;
        term = tr;
        acc = acc + (term <<< FRAC_BITS);
        acc = acc >>> FRAC_BITS;
        if (acc > WIDE_MAX) return COORD_MAX;
        if (acc < WIDE_MIN) return COORD_MIN;
        return acc[COORD_W-1:0];
    endfunction

    // Advances the predicted state by one accepted beat. Returns 1 when the
    // beat produces a box, which is then left in res.
    function automatic bit predict_box(beat_t b, output box_t res);
        t_coord corner [3];
        t_coord img [3];
        if (b.action == ACT_POINT) begin
            // The first point of a run sets both corners outright.
            for (int i = 0; i < 3; i++) begin
                if (!run_open || b.first[i] < run_lo[i]) run_lo[i] = b.first[i];
                if (!run_open || b.first[i] > run_hi[i]) run_hi[i] = b.first[i];
            end
            run_open = 1'b1;
            if (!b.last) return 1'b0;
            res.lo = run_lo;
            res.hi = run_hi;
            run_open = 1'b0;
            return 1'b1;
        end
        // A box beat: corners are taken as given, even when inverted, and
        // the open point run is not touched.
        for (int k = 0; k < 8; k++) begin
            corner[0] = ((k & 4) != 0) ? b.second[0] : b.first[0];
            corner[1] = ((k & 1) != 0) ? b.second[1] : b.first[1];
            corner[2] = ((k & 2) != 0) ? b.second[2] : b.first[2];
            for (int r = 0; r < 3; r++) begin
                img[r] = affine_axis(r, corner[0], corner[1], corner[2]);
            end
            for (int i = 0; i < 3; i++) begin
                if (k == 0 || img[i] < res.lo[i]) res.lo[i] = img[i];
                if (k == 0 || img[i] > res.hi[i]) res.hi[i] = img[i];
            end
        end
        return 1'b1;
    endfunction

    // Coordinates lean toward the extremes and toward small values, where
    // the products neither vanish nor saturate at once.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3, 4, 5: return t_coord'($urandom_range(0, 32'h001F_FFFF)) -
                            t_coord'(32'h0010_0000);
            default: return t_coord'($urandom());
        endcase
    endfunction

    // Coefficients mostly within about four units either way.
    function automatic t_coef rand_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return COEF_ONE;
            2: return -COEF_ONE;
            3: return t_coef'($urandom());
            default: return t_coef'($urandom_range(0, 32'h0007_FFFF)) -
                            t_coef'(32'h0004_0000);
        endcase
    endfunction

    task automatic push_beat(logic act, t_coord fx, t_coord fy, t_coord fz,
                             t_coord sx, t_coord sy, t_coord sz, logic lst);
        beat_t b;
        b.action    = act;
        b.first[0]  = fx;
        b.first[1]  = fy;
        b.first[2]  = fz;
        b.second[0] = sx;
        b.second[1] = sy;
        b.second[2] = sz;
        b.last      = lst;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic push_rand_beat(logic act, logic lst);
        push_beat(act, rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord(), lst);
    endtask

    // Mostly whole point runs and boxes, some of them inside an open run,
    // with a sprinkling of lone points whose last flag is a coin toss.
    task automatic push_random(int count);
        int done;
        int run_len;
        int pick;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                push_rand_beat(ACT_BOX, 1'($urandom()));
                done++;
            end else if (pick < 9) begin
                run_len = $urandom_range(1, 6);
                for (int i = 0; i < run_len; i++) begin
                    // Now and then a box lands in the middle of a run.
                    if (i > 0 && $urandom_range(0, 7) == 0) begin
                        push_rand_beat(ACT_BOX, 1'($urandom()));
                        done++;
                    end
                    push_rand_beat(ACT_POINT, i == run_len - 1);
                    done++;
                end
            end else begin
                push_rand_beat(ACT_POINT, 1'($urandom()));
                done++;
            end
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, t_cfg value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx < NUM_CFG) matrix_shadow[idx] = value;
    endtask

    // Builds a matrix of the given kind and writes all six registers,
    // optionally followed by writes to the unused indexes.
    task automatic load_matrix(matrix_kind_e kind, bit spare_writes);
        t_coef    m [3][4];
        t_cfg_idx reg_order [NUM_CFG];
        reg_order = '{REG_ROW0_COLS01, REG_ROW0_COLS23, REG_ROW1_COLS01,
                      REG_ROW1_COLS23, REG_ROW2_COLS01, REG_ROW2_COLS23};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                case (kind)
                    MAT_IDENTITY, MAT_SHIFTED: m[r][c] = (c == r) ? COEF_ONE : '0;
                    MAT_ALL_MAX:  m[r][c] = COEF_MAX;
                    MAT_ALL_MIN:  m[r][c] = COEF_MIN;
                    MAT_ZERO:     m[r][c] = '0;
                    MAT_MODERATE: m[r][c] = rand_coef();
                    default:      m[r][c] = t_coef'($urandom());
                endcase
            end
        end
        if (kind == MAT_SHIFTED) begin
            m[0][3] = COEF_MAX;
            m[1][3] = COEF_MIN;
            m[2][3] = t_coef'($urandom());
        end
        for (int r = 0; r < 3; r++) begin
            write_reg(reg_order[2*r],     {m[r][1], m[r][0]});
            write_reg(reg_order[2*r + 1], {m[r][3], m[r][2]});
        end
        if (spare_writes) begin
            write_reg(REG_BEYOND_FIRST, {$urandom(), $urandom()});
            write_reg(REG_BEYOND_LAST,  {$urandom(), $urandom()});
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Waits until every queued beat is taken and every box has come back,
    // then lets the pipeline settle, since a point without last leaves no
    // result to wait for.
    task automatic wait_drained();
        @(negedge i_clk);
        while (beats_accepted != beats_queued || expected_boxes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(matrix_kind_e kind, bit spare_writes, int count,
                             bit no_idle);
        load_matrix(kind, spare_writes);
        calm = no_idle;
        push_random(count);
        wait_drained();
    endtask

    // Driver: presents queued beats, predicts on each accepted beat, and
    // idles for a random number of cycles after each one unless calm is set.
    always @(posedge i_clk) begin : driver
        beat_t on_bus;
        box_t  predicted;
        int    send_gap;
        bit    has_box;
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                beats_accepted++;
                has_box = predict_box(on_bus, predicted);
                if (has_box) expected_boxes.push_back(predicted);
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_bus.valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    on_bus = pending_beats.pop_front();
                    in_bus.action   <= on_bus.action;
                    in_bus.first_x  <= on_bus.first[0];
                    in_bus.first_y  <= on_bus.first[1];
                    in_bus.first_z  <= on_bus.first[2];
                    in_bus.second_x <= on_bus.second[0];
                    in_bus.second_y <= on_bus.second[1];
                    in_bus.second_z <= on_bus.second[2];
                    in_bus.last     <= on_bus.last;
                    in_bus.valid    <= 1'b1;
                    send_gap = calm ? 0 : $urandom_range(0, MAX_IDLE);
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes result beats and checks them against the oldest predicted
    // box. Unless calm is set, it stalls for a random number of cycles after
    // each one, and stalls also start now and then while nothing is offered.
    always @(posedge i_clk) begin : monitor
        box_t want;
        box_t got;
        int   recv_stall;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_boxes.size() == 0) begin
                    $error("result beat with no box predicted");
                    error_count++;
                end else begin
                    want = expected_boxes.pop_front();
                    got.lo = '{res_bus.min_x, res_bus.min_y, res_bus.min_z};
                    got.hi = '{res_bus.max_x, res_bus.max_y, res_bus.max_z};
                    for (int i = 0; i < 3; i++) begin
                        if (got.lo[i] !== want.lo[i]) begin
                            $error("%s: expected %0d, got %0d",
                                   lo_name[i], want.lo[i], got.lo[i]);
                            error_count++;
                        end
                        if (got.hi[i] !== want.hi[i]) begin
                            $error("%s: expected %0d, got %0d",
                                   hi_name[i], want.hi[i], got.hi[i]);
                            error_count++;
                        end
                    end
                end
                recv_stall = calm ? 0 : $urandom_range(0, MAX_IDLE);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                recv_stall = $urandom_range(1, MAX_IDLE);
            end
            res_bus.ready <= (recv_stall == 0);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = REG_ROW0_COLS01;
        i_cfg_data      = '0;
        in_bus.valid    = 1'b0;
        in_bus.action   = ACT_POINT;
        in_bus.first_x  = '0;
        in_bus.first_y  = '0;
        in_bus.first_z  = '0;
        in_bus.second_x = '0;
        in_bus.second_y = '0;
        in_bus.second_z = '0;
        in_bus.last     = 1'b0;
        res_bus.ready   = 1'b0;
        matrix_shadow   = CFG_RESET;
        run_open        = 1'b0;
        run_lo          = '{default: '0};
        run_hi          = '{default: '0};
        beats_queued    = 0;
        beats_accepted  = 0;
        error_count     = 0;
        cycle_count     = 0;
        calm            = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats under the identity matrix left by reset.
        // A lone last point: the box is that single point.
        push_beat(ACT_POINT, COORD_MAX, COORD_MIN, '0, '0, '0, '0, 1'b1);
        // A run of three points with a box in the middle; the box must not
        // disturb the run, and its last flag means nothing.
        push_beat(ACT_POINT, 32'sd1, 32'sd2, 32'sd3, COORD_MAX, COORD_MAX,
                  COORD_MAX, 1'b0);
        push_beat(ACT_POINT, -32'sd5, 32'sd10, COORD_MIN, '0, '0, '0, 1'b0);
        push_beat(ACT_BOX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                  COORD_MAX, COORD_MAX, 1'b1);
        push_beat(ACT_POINT, COORD_MAX, '0, -32'sd1, '0, '0, '0, 1'b1);
        // Inverted corners, a degenerate box and an all-zero box.
        push_beat(ACT_BOX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                  COORD_MIN, COORD_MIN, 1'b0);
        push_beat(ACT_BOX, 32'sh1234_5678, -32'sh0765_4321, 32'sh0001_8000,
                  32'sh1234_5678, -32'sh0765_4321, 32'sh0001_8000, 1'b0);
        push_beat(ACT_BOX, '0, '0, '0, '0, '0, '0, 1'b0);
        // Points at all ones, then the two extremes of every axis.
        push_beat(ACT_POINT, -32'sd1, -32'sd1, -32'sd1, COORD_MAX, COORD_MIN,
                  COORD_MAX, 1'b1);
        push_beat(ACT_POINT, COORD_MIN, COORD_MIN, COORD_MIN, '0, '0, '0, 1'b0);
        push_beat(ACT_POINT, COORD_MAX, COORD_MAX, COORD_MAX, '0, '0, '0, 1'b1);
        push_random(30);
        wait_drained();

        // Saturating translations, full-scale coefficients of both signs,
        // the zero matrix, then random matrices with and without idling.
        run_phase(MAT_SHIFTED, 1'b0, 40, 1'b0);
        run_phase(MAT_ALL_MAX, 1'b0, 30, 1'b0);
        run_phase(MAT_ALL_MIN, 1'b1, 30, 1'b1);
        run_phase(MAT_ZERO, 1'b1, 25, 1'b0);
        for (int p = 0; p < 7; p++) begin
            run_phase((p % 3 == 2) ? MAT_WILD : MAT_MODERATE, p[0], 35, p == 3);
        end
        run_phase(MAT_IDENTITY, 1'b0, 20, 1'b0);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
